// File: src/tgau_pkg.sv
// tgau_pkg: shared types and codes for the tensor gather address unit
// no dependencies; used by tgau_front, tgau_back and the top level by scoped name

package tgau_pkg;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		REG_OUTPUT_DIMS   = 3'd0,
		REG_INPUT_DIMS    = 3'd1,
		REG_INPUT_STRIDES = 3'd2,
		REG_INDEX_DIMS    = 3'd3,
		REG_GATHER_AXIS   = 3'd4,
		REG_OUTPUT_RANK   = 3'd5,
		REG_INPUT_RANK    = 3'd6,
		REG_INDEX_RANK    = 3'd7
	} cfg_reg_t;

	// one classified request from the front queue
	typedef struct packed {
		kind_t              kind;
		logic [31:0]        position;
		logic signed [15:0] index_value;
	} item_t;

	// ranks and axis after clamping and normalisation
	typedef struct packed {
		logic [2:0] orank;
		logic [2:0] irank;
		logic [2:0] xrank;
		logic [2:0] axis;
	} shape_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [7:0]  index_slot;
		logic        out_of_range;
	} result_t;

endpackage

// File: src/tgau_ram.sv
// tgau_ram: generic single write port, single read port memory, registered read
// no dependencies

module tgau_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/tgau_div.sv
// tgau_div: pipelined restoring divider, one quotient bit per stage
// no dependencies; carries an opaque payload alongside the operands

module tgau_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [PW-1:0] in_payload,
	output logic          out_valid,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder,
	output logic [PW-1:0] out_payload
);

	logic          vld_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [PW-1:0] pl_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          src_v;
		logic [DW-1:0] src_rem;
		logic [NW-1:0] src_num;
		logic [PW-1:0] src_pl;
		logic [DW:0]   trial;
		logic          ge;
		logic [DW-1:0] rem_next;

		if (k == 0) begin : g_first
			assign src_v   = in_valid;
			assign src_rem = '0;
			assign src_num = dividend;
			assign src_pl  = in_payload;
		end else begin : g_next
			assign src_v   = vld_s[k-1];
			assign src_rem = rem_s[k-1];
			assign src_num = num_s[k-1];
			assign src_pl  = pl_s[k-1];
		end

		always_comb begin
			trial    = {src_rem, src_num[NW-1]};
			ge       = (trial >= {1'b0, divisor});
			rem_next = ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_next;
				num_s[k] <= {src_num[NW-2:0], ge};
				pl_s[k]  <= src_pl;
			end
		end
	end

	assign out_valid   = vld_s[NW-1];
	assign quotient    = num_s[NW-1];
	assign remainder   = rem_s[NW-1];
	assign out_payload = pl_s[NW-1];

endmodule

// File: src/tgau_front.sv
// tgau_front: input side queue, accepts and holds incoming requests
// depends on tgau_pkg

module tgau_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  tgau_pkg::item_t in_item,
	output logic            out_valid,
	output tgau_pkg::item_t out_item,
	input  logic            take
);

	tgau_pkg::item_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            acc;
	logic            deq;

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign out_valid = (cnt_q != 2'd0);
	assign deq       = take && out_valid;
	assign out_item  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
			end
			if (deq) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_q] <= in_item;
		end
	end

endmodule

// File: src/tgau_back.sv
// tgau_back: unravel dividers, index slot steps, index table and address sum
// depends on tgau_pkg, tgau_div and tgau_ram

module tgau_back #(
	parameter int MAX_RANK    = 4,
	parameter int INDEX_DEPTH = 256,
	parameter int DIM_WIDTH   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        output_dims,
	input  logic [63:0]        input_dims,
	input  logic [63:0]        input_strides,
	input  logic [63:0]        index_dims,
	input  tgau_pkg::shape_t   shape,
	input  logic               in_valid,
	input  tgau_pkg::item_t    in_item,
	output logic               in_ready,
	output logic               empty,
	input  logic               pop,
	output tgau_pkg::result_t  result
);

	localparam int XSTEPS     = (MAX_RANK < 3) ? MAX_RANK : 3;
	localparam int AW         = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
	localparam int DEPTH_BITS = $clog2(INDEX_DEPTH + 1);
	localparam bit DEPTH_POW2 = ((INDEX_DEPTH & (INDEX_DEPTH - 1)) == 0);

	typedef logic [MAX_RANK-1:0][31:0]          coord_t;
	typedef logic [MAX_RANK-1:0][DIM_WIDTH-1:0] dims_t;

	typedef struct packed {
		tgau_pkg::item_t item;
		logic [31:0]     rest;
		coord_t          oc;
	} unr_t;

	typedef struct packed {
		tgau_pkg::item_t item;
		coord_t          oc;
		logic [63:0]     slot;
	} idx_t;

	function automatic logic [DIM_WIDTH-1:0] fld(input dims_t arr, input int k);
		logic [DIM_WIDTH-1:0] r;
		r = '0;
		for (int m = 0; m < MAX_RANK; m++) begin
			if (m == k) begin
				r = arr[m];
			end
		end
		return r;
	endfunction

	// coordinate k of the output, zero where k lies beyond the output rank
	function automatic logic [31:0] coord_at(input coord_t oc, input int k, input int orank);
		logic [31:0] r;
		r = '0;
		for (int m = 0; m < MAX_RANK; m++) begin
			if (m == k && m < orank) begin
				r = oc[m];
			end
		end
		return r;
	endfunction

	dims_t odim, idim, istr, xdim;
	int    orank_i, irank_i, xrank_i, axis_i;
	logic  en;

	assign orank_i = int'(shape.orank);
	assign irank_i = int'(shape.irank);
	assign xrank_i = int'(shape.xrank);
	assign axis_i  = int'(shape.axis);

	for (genvar k = 0; k < MAX_RANK; k++) begin : g_fld
		if ((k + 1) * DIM_WIDTH <= 64) begin : g_full
			assign odim[k] = output_dims[k*DIM_WIDTH +: DIM_WIDTH];
			assign idim[k] = input_dims[k*DIM_WIDTH +: DIM_WIDTH];
			assign istr[k] = input_strides[k*DIM_WIDTH +: DIM_WIDTH];
			assign xdim[k] = index_dims[k*DIM_WIDTH +: DIM_WIDTH];
		end else if (k * DIM_WIDTH < 64) begin : g_part
			localparam int LoW = 64 - k * DIM_WIDTH;
			assign odim[k] = DIM_WIDTH'(output_dims[63 -: LoW]);
			assign idim[k] = DIM_WIDTH'(input_dims[63 -: LoW]);
			assign istr[k] = DIM_WIDTH'(input_strides[63 -: LoW]);
			assign xdim[k] = DIM_WIDTH'(index_dims[63 -: LoW]);
		end else begin : g_none
			assign odim[k] = '0;
			assign idim[k] = '0;
			assign istr[k] = '0;
			assign xdim[k] = '0;
		end
	end

	assign in_ready = en;

	// unravel: one divider per output dimension, innermost first
	unr_t uchain [MAX_RANK+1];
	logic uvalid [MAX_RANK+1];

	assign uchain[0] = '{item: in_item, rest: in_item.position, oc: '0};
	assign uvalid[0] = in_valid;

	for (genvar j = 0; j < MAX_RANK; j++) begin : g_unr
		unr_t                 dpl;
		unr_t                 nxt;
		logic                 dvalid;
		logic [31:0]          quo;
		logic [DIM_WIDTH-1:0] rem;

		tgau_div #(
			.NW(32),
			.DW(DIM_WIDTH),
			.PW($bits(unr_t))
		) u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in_valid   (uvalid[j]),
			.dividend   (uchain[j].rest),
			.divisor    (odim[j]),
			.in_payload (uchain[j]),
			.out_valid  (dvalid),
			.quotient   (quo),
			.remainder  (rem),
			.out_payload(dpl)
		);

		always_comb begin
			nxt = dpl;
			if (dpl.item.kind == tgau_pkg::KIND_REQUEST && j < orank_i) begin
				for (int m = 0; m < MAX_RANK; m++) begin
					if (m == orank_i - 1 - j) begin
						if (odim[j] == '0) begin
							nxt.oc[m] = '0;
						end else if (j == orank_i - 1) begin
							// outermost keeps whatever is left, no wrap
							nxt.oc[m] = dpl.rest;
						end else begin
							nxt.oc[m] = 32'(rem);
						end
					end
				end
				if (odim[j] != '0 && j != orank_i - 1) begin
					nxt.rest = quo;
				end
			end
		end

		assign uchain[j+1] = nxt;
		assign uvalid[j+1] = dvalid;
	end

	// index slot, row-major over the index dimensions, 64-bit wrap
	idx_t xchain [XSTEPS+1];
	logic xvalid [XSTEPS+1];

	assign xchain[0] = '{item: uchain[MAX_RANK].item, oc: uchain[MAX_RANK].oc, slot: '0};
	assign xvalid[0] = uvalid[MAX_RANK];

	for (genvar i = 0; i < XSTEPS; i++) begin : g_idx
		logic        on;
		logic [31:0] len32;
		logic [31:0] cin;
		logic        a_v_s1;
		idx_t        a_pl_s1;
		logic [63:0] a_lo_s1;
		logic [31:0] a_hi_s1;
		logic [31:0] a_c_s1;
		logic        a_on_s1;
		idx_t        b_nxt;
		logic        b_v_s2;
		idx_t        b_pl_s2;

		always_comb begin
			on    = (xchain[i].item.kind == tgau_pkg::KIND_REQUEST) && (i < xrank_i);
			len32 = 32'(fld(xdim, xrank_i - 1 - i));
			cin   = coord_at(xchain[i].oc, axis_i + i, orank_i);
		end

		// second half of the step: recombine the partial products
		always_comb begin
			b_nxt = a_pl_s1;
			if (a_on_s1) begin
				b_nxt.slot = a_lo_s1 + {a_hi_s1, 32'b0} + {32'b0, a_c_s1};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_v_s1 <= 1'b0;
				b_v_s2 <= 1'b0;
			end else if (en) begin
				a_v_s1 <= xvalid[i];
				b_v_s2 <= a_v_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_pl_s1 <= xchain[i];
				a_lo_s1 <= {32'b0, xchain[i].slot[31:0]} * {32'b0, len32};
				a_hi_s1 <= xchain[i].slot[63:32] * len32;
				a_c_s1  <= cin;
				a_on_s1 <= on;
				b_pl_s2 <= b_nxt;
			end
		end

		assign xchain[i+1] = b_pl_s2;
		assign xvalid[i+1] = b_v_s2;
	end

	// table address: loads use their own slot, requests the gathered slot
	idx_t          kpl;
	logic [63:0]   key;
	logic          t_v;
	idx_t          t_pl;
	logic [AW-1:0] t_addr;

	assign kpl = xchain[XSTEPS];
	assign key = (kpl.item.kind == tgau_pkg::KIND_REQUEST) ? kpl.slot
		: {32'b0, kpl.item.position};

	if (DEPTH_POW2) begin : g_mask
		assign t_v    = xvalid[XSTEPS];
		assign t_pl   = kpl;
		assign t_addr = AW'(key & 64'(INDEX_DEPTH - 1));
	end else begin : g_mod
		logic [DEPTH_BITS-1:0] mod_r;

		tgau_div #(
			.NW(64),
			.DW(DEPTH_BITS),
			.PW($bits(idx_t))
		) u_mod (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in_valid   (xvalid[XSTEPS]),
			.dividend   (key),
			.divisor    (DEPTH_BITS'(INDEX_DEPTH)),
			.in_payload (kpl),
			.out_valid  (t_v),
			.quotient   (),
			.remainder  (mod_r),
			.out_payload(t_pl)
		);

		assign t_addr = AW'(mod_r);
	end

	logic        ram_we;
	logic [15:0] ram_rdata;

	assign ram_we = en && t_v && (t_pl.item.kind == tgau_pkg::KIND_LOAD);

	tgau_ram #(
		.WIDTH(16),
		.DEPTH(INDEX_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(t_addr),
		.wdata(t_pl.item.index_value),
		.re   (en),
		.raddr(t_addr),
		.rdata(ram_rdata)
	);

	// table read stage
	logic       rd_v_s1;
	logic       rd_req_s1;
	coord_t     rd_oc_s1;
	logic [7:0] rd_slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else if (en) begin
			rd_v_s1 <= t_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_req_s1  <= (t_pl.item.kind == tgau_pkg::KIND_REQUEST);
			rd_oc_s1   <= t_pl.oc;
			rd_slot_s1 <= 8'(t_addr);
		end
	end

	// range check and per-dimension products
	logic [31:0] alen;
	logic [31:0] gval;
	logic        oor;
	coord_t      lane_c;
	coord_t      lane_prod;

	always_comb begin
		alen = 32'(fld(idim, irank_i - 1 - axis_i));
		oor  = ram_rdata[15] || ({16'b0, ram_rdata} >= alen);
		gval = oor ? '0 : {16'b0, ram_rdata};
		for (int i = 0; i < MAX_RANK; i++) begin
			if (i < axis_i) begin
				lane_c[i] = coord_at(rd_oc_s1, i, orank_i);
			end else if (i == axis_i) begin
				lane_c[i] = gval;
			end else begin
				lane_c[i] = coord_at(rd_oc_s1, i + xrank_i - 1, orank_i);
			end
			lane_prod[i] = (i < irank_i)
				? lane_c[i] * 32'(fld(istr, irank_i - 1 - i)) : '0;
		end
	end

	logic       mul_v_s2;
	logic       mul_req_s2;
	coord_t     mul_prod_s2;
	logic       mul_oor_s2;
	logic [7:0] mul_slot_s2;
	logic [31:0] addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else if (en) begin
			mul_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_req_s2  <= rd_req_s1;
			mul_prod_s2 <= lane_prod;
			mul_oor_s2  <= oor;
			mul_slot_s2 <= rd_slot_s1;
		end
	end

	always_comb begin
		addr_sum = '0;
		for (int m = 0; m < MAX_RANK; m++) begin
			addr_sum = addr_sum + mul_prod_s2[m];
		end
	end

	// result queue, two entries
	tgau_pkg::result_t oq_q [2];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;
	logic              o_push;
	logic              o_pop;

	assign en     = (ocnt_q != 2'd2);
	assign o_push = en && mul_v_s2 && mul_req_s2;
	assign o_pop  = pop && (ocnt_q != 2'd0);
	assign empty  = (ocnt_q == 2'd0);
	assign result = oq_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (o_push) begin
				owr_q <= !owr_q;
			end
			if (o_pop) begin
				ord_q <= !ord_q;
			end
			ocnt_q <= ocnt_q + 2'(o_push) - 2'(o_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (o_push) begin
			oq_q[owr_q] <= '{source_address: addr_sum, index_slot: mul_slot_s2,
				out_of_range: mul_oor_s2};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rd_v_s1) && $stable(mul_v_s2))
		else $error("pipeline moved while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ocnt_q == 2'd2 && !o_pop) |=> ocnt_q == 2'd2)
		else $error("result lost from full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		t_v |-> int'(t_addr) < INDEX_DEPTH)
		else $error("table address beyond depth");

endmodule

// File: src/tensor_gather_address_unit.sv
// tensor_gather_address_unit: top level, configuration registers and wiring
// depends on tgau_pkg, tgau_front and tgau_back

// Gather address generator. Load requests (kind 0) write a signed index value
// into the index table at position modulo INDEX_DEPTH; address requests
// (kind 1) give an output element position and return the source address,
// the table slot used and an out-of-range flag, in order. One item is taken
// per cycle while the result queue has room, back to back, loads and requests
// mixed freely. The position is unravelled by restoring dividers, one quotient
// bit per stage and one divider per output dimension; if INDEX_DEPTH is not a
// power of two, a further divider takes the table address modulo INDEX_DEPTH.
// Loads pass through the same pipeline, so a load and a later request always
// see the table in request order. The user must write configuration through
// its own port only while no item is in flight; the block does not enforce
// it. The table holds nothing meaningful until loaded.

module tensor_gather_address_unit #(
	parameter int MAX_RANK    = 4,
	parameter int INDEX_DEPTH = 256,
	parameter int DIM_WIDTH   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic [31:0]        position,
	input  logic signed [15:0] index_value,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        source_address,
	output logic [7:0]         index_slot,
	output logic               out_of_range,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam logic [2:0] MaxRank = 3'(MAX_RANK);

	logic [63:0] output_dims_q;
	logic [63:0] input_dims_q;
	logic [63:0] input_strides_q;
	logic [63:0] index_dims_q;
	logic [2:0]  gather_axis_q;
	logic [2:0]  output_rank_q;
	logic [2:0]  input_rank_q;
	logic [1:0]  index_rank_q;

	tgau_pkg::shape_t  shape;
	logic signed [4:0] axis_norm;
	tgau_pkg::item_t   in_item;
	logic              fq_valid;
	tgau_pkg::item_t   fq_item;
	logic              back_ready;
	tgau_pkg::result_t result;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_dims_q   <= '0;
			input_dims_q    <= '0;
			input_strides_q <= '0;
			index_dims_q    <= '0;
			gather_axis_q   <= '0;
			output_rank_q   <= 3'd1;
			input_rank_q    <= 3'd1;
			index_rank_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tgau_pkg::cfg_reg_t'(cfg_index))
				tgau_pkg::REG_OUTPUT_DIMS:   output_dims_q   <= cfg_data;
				tgau_pkg::REG_INPUT_DIMS:    input_dims_q    <= cfg_data;
				tgau_pkg::REG_INPUT_STRIDES: input_strides_q <= cfg_data;
				tgau_pkg::REG_INDEX_DIMS:    index_dims_q    <= cfg_data;
				tgau_pkg::REG_GATHER_AXIS:   gather_axis_q   <= cfg_data[2:0];
				tgau_pkg::REG_OUTPUT_RANK:   output_rank_q   <= cfg_data[2:0];
				tgau_pkg::REG_INPUT_RANK:    input_rank_q    <= cfg_data[2:0];
				tgau_pkg::REG_INDEX_RANK:    index_rank_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// clamp the ranks, then bring the axis into the input rank
	always_comb begin
		shape.orank = (output_rank_q > MaxRank) ? MaxRank : output_rank_q;
		if (input_rank_q == 3'd0) begin
			shape.irank = 3'd1;
		end else if (input_rank_q > MaxRank) begin
			shape.irank = MaxRank;
		end else begin
			shape.irank = input_rank_q;
		end
		shape.xrank = ({1'b0, index_rank_q} > MaxRank) ? MaxRank : {1'b0, index_rank_q};
		// negative axis counts back from the input rank
		axis_norm = 5'(signed'(gather_axis_q));
		if (axis_norm < 0) begin
			axis_norm = axis_norm + signed'({2'b00, shape.irank});
		end
		if (axis_norm < 0) begin
			axis_norm = '0;
		end
		if (axis_norm >= signed'({2'b00, shape.irank})) begin
			axis_norm = signed'({2'b00, shape.irank}) - 5'sd1;
		end
		shape.axis = 3'(axis_norm);
	end

	assign in_item = '{kind: tgau_pkg::kind_t'(kind), position: position,
		index_value: index_value};

	tgau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.out_valid(fq_valid),
		.out_item (fq_item),
		.take     (back_ready)
	);

	tgau_back #(
		.MAX_RANK   (MAX_RANK),
		.INDEX_DEPTH(INDEX_DEPTH),
		.DIM_WIDTH  (DIM_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.output_dims  (output_dims_q),
		.input_dims   (input_dims_q),
		.input_strides(input_strides_q),
		.index_dims   (index_dims_q),
		.shape        (shape),
		.in_valid     (fq_valid),
		.in_item      (fq_item),
		.in_ready     (back_ready),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

	assign source_address = result.source_address;
	assign index_slot     = result.index_slot;
	assign out_of_range   = result.out_of_range;

endmodule
